FILE: design/fce_pkg.sv
// Shared types and constants for the fragment coordinate encoder.
// Used by fce_tracker, fce_packer and fragment_coordinate_encoder_unit; no dependencies.

package fce_pkg;

    // Default sizing of the unit.
    localparam int DEF_MAX_WIDTH     = 4096;
    localparam int DEF_MAX_FRAGMENTS = 32;

    // Output code word.
    localparam int OUT_BITS   = 47;
    localparam int CODE_LEN_W = 6;

    // Configuration port.
    localparam int CFG_DATA_W = 13;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNIT_LENGTH    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAGMENT_COUNT = 2'd2;

    localparam int RST_IMAGE_WIDTH    = 4096;
    localparam int RST_UNIT_LENGTH    = 128;
    localparam int RST_FRAGMENT_COUNT = 32;

    // Pixel classes.
    typedef enum logic [1:0] {
        CLASS_EMPTY       = 2'd0,
        CLASS_UPPER_LEFT  = 2'd1,
        CLASS_LOWER_RIGHT = 2'd2,
        CLASS_POINT       = 2'd3
    } t_fce_class;

    // Prefix codes, right aligned; their lengths are set in fce_packer.
    localparam logic [2:0] PFX_UPPER_LEFT  = 3'b011;
    localparam logic [2:0] PFX_LOWER_RIGHT = 3'b101;
    localparam logic [2:0] PFX_POINT       = 3'b100;
    localparam logic [2:0] PFX_EMPTY       = 3'b000;

    // Per-pixel control handed from the tracker to the code builder.
    typedef struct packed {
        logic       head_en;  // a prefix (or the lone 0 of an empty fragment end) is emitted
        logic       skip;     // gap field omitted
        t_fce_class pix;
    } t_fce_flags;

endpackage

FILE: design/fce_tracker.sv
// Row and fragment position tracking for the fragment coordinate encoder.
// Depends on fce_pkg; produces a per-pixel descriptor for fce_packer.

module fce_tracker #(
    parameter int MAX_WIDTH     = fce_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FRAGMENTS = fce_pkg::DEF_MAX_FRAGMENTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_restart,
    input  logic                         i_accept,
    input  logic [1:0]                   i_pixel_class,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_w_last,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_u_last,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_u,
    input  logic [$clog2(MAX_FRAGMENTS+1)-1:0] i_n,
    output fce_pkg::t_fce_flags          o_flags,
    output logic [$clog2(MAX_WIDTH+1)-1:0] o_span,
    output logic [$clog2(MAX_WIDTH)-1:0] o_gap,
    output logic [$clog2(MAX_FRAGMENTS+1)-1:0] o_zeros
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH);
    localparam int FW = $clog2(MAX_FRAGMENTS + 1);

    logic [PW-1:0] r_column, n_column;
    logic [PW-1:0] r_pos, n_pos;
    logic [FW-1:0] r_frag, n_frag;
    // Previous nonzero position plus one, so that "none" is zero.
    logic [WW-1:0] r_lp, n_lp;

    logic row_end;
    logic frag_wrap;
    logic frag_end;
    logic active;
    logic nonzero;
    logic skip;

    always_comb begin
        row_end   = (r_column == i_w_last);
        frag_wrap = (r_pos == i_u_last);
        frag_end  = frag_wrap || row_end;
        active    = (r_frag < i_n);
        nonzero   = (i_pixel_class != fce_pkg::CLASS_EMPTY);
        skip      = (r_lp == WW'(i_u_last));

        o_flags.head_en = active && (nonzero || frag_end);
        o_flags.skip    = skip;
        o_flags.pix     = fce_pkg::t_fce_class'(i_pixel_class);
        o_span          = i_u - r_lp;
        o_gap           = r_pos - PW'(r_lp);
        if (row_end && active && ((r_frag + FW'(1)) < i_n)) begin
            o_zeros = i_n - r_frag - FW'(1);
        end else begin
            o_zeros = '0;
        end
    end

    always_comb begin
        n_column = r_column;
        n_pos    = r_pos;
        n_frag   = r_frag;
        n_lp     = r_lp;
        if (row_end) begin
            n_column = '0;
            n_pos    = '0;
            n_frag   = '0;
            n_lp     = '0;
        end else begin
            n_column = r_column + PW'(1);
            if (frag_wrap) begin
                n_pos = '0;
                n_lp  = '0;
                if (active) begin
                    n_frag = r_frag + FW'(1);
                end
            end else begin
                n_pos = r_pos + PW'(1);
                if (active && nonzero) begin
                    n_lp = skip ? (r_lp + WW'(1)) : (WW'(r_pos) + WW'(1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_column <= '0;
            r_pos    <= '0;
            r_frag   <= '0;
            r_lp     <= '0;
        end else if (i_accept) begin
            r_column <= n_column;
            r_pos    <= n_pos;
            r_frag   <= n_frag;
            r_lp     <= n_lp;
        end
    end

`ifndef ASSERT_OFF
    a_pos_in_fragment : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= i_u_last)
        else $error("position within fragment ran past the fragment end");

    a_column_in_row : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_column <= i_w_last)
        else $error("column ran past the row end");

    a_last_in_fragment : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lp <= i_u) && (r_frag <= i_n))
        else $error("last nonzero position or fragment index out of range");
`endif

endmodule

FILE: design/fce_packer.sv
// Code builder for the fragment coordinate encoder: descriptor register,
// prefix and gap assembly, trailing zero fill and output register. Depends on fce_pkg.

module fce_packer #(
    parameter int MAX_WIDTH     = fce_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FRAGMENTS = fce_pkg::DEF_MAX_FRAGMENTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  fce_pkg::t_fce_flags                i_flags,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     i_span,
    input  logic [$clog2(MAX_WIDTH)-1:0]       i_gap,
    input  logic [$clog2(MAX_FRAGMENTS+1)-1:0] i_zeros,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [fce_pkg::OUT_BITS-1:0]       o_code_bits,
    output logic [fce_pkg::CODE_LEN_W-1:0]     o_code_length
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH);
    localparam int FW = $clog2(MAX_FRAGMENTS + 1);
    localparam int BW = $clog2(PW + 1);
    localparam int HW = PW + 3;
    localparam int LW = $clog2(HW + 1);
    localparam int OW = fce_pkg::OUT_BITS;
    localparam int CW = fce_pkg::CODE_LEN_W;

    // Stage A: descriptor of the accepted pixel.
    logic                r_a_valid;
    fce_pkg::t_fce_flags r_a_flags;
    logic [WW-1:0]       r_a_span;
    logic [PW-1:0]       r_a_gap;
    logic [FW-1:0]       r_a_zeros;

    // Stage B: prefix and gap joined into one head word.
    logic                r_b_valid;
    logic [HW-1:0]       r_b_head, n_b_head;
    logic [LW-1:0]       r_b_hlen, n_b_hlen;
    logic [FW-1:0]       r_b_zeros;

    // Output register.
    logic                r_out_valid;
    logic [OW-1:0]       r_out_bits, n_out_bits;
    logic [CW-1:0]       r_out_len, n_out_len;

    logic en_a;
    logic en_b;
    logic en_c;

    logic [PW-1:0] span_m1;
    logic [BW-1:0] bit_len;
    logic [BW-1:0] gap_bits;
    logic [PW:0]   gap_ones;
    logic [PW-1:0] gap_mask;
    logic [2:0]    pfx;
    logic [1:0]    pfx_len;

    logic [CW-1:0] room;
    logic [7:0]    zeros_w;
    logic [7:0]    room_w;
    logic [CW-1:0] fill;

    // A stage takes new data when it is empty or its content moves on.
    assign en_c    = !r_out_valid || i_ready;
    assign en_b    = !r_b_valid || en_c;
    assign en_a    = !r_a_valid || en_b;
    assign o_ready = en_a;

    // Gap width is the bit length of span-1, at least one bit.
    always_comb begin
        span_m1 = PW'(r_a_span - WW'(1));
        bit_len = '0;
        for (int i = 0; i < PW; i++) begin
            if (span_m1[i]) begin
                bit_len = BW'(i + 1);
            end
        end
        gap_bits = (bit_len == '0) ? BW'(1) : bit_len;
        gap_ones = ((PW + 1)'(1) << gap_bits) - (PW + 1)'(1);
        gap_mask = gap_ones[PW-1:0];
    end

    always_comb begin
        unique case (r_a_flags.pix)
            fce_pkg::CLASS_EMPTY: begin
                pfx     = fce_pkg::PFX_EMPTY;
                pfx_len = 2'd1;
            end
            fce_pkg::CLASS_UPPER_LEFT: begin
                pfx     = fce_pkg::PFX_UPPER_LEFT;
                pfx_len = 2'd2;
            end
            fce_pkg::CLASS_LOWER_RIGHT: begin
                pfx     = fce_pkg::PFX_LOWER_RIGHT;
                pfx_len = 2'd3;
            end
            fce_pkg::CLASS_POINT: begin
                pfx     = fce_pkg::PFX_POINT;
                pfx_len = 2'd3;
            end
            default: begin
                pfx     = fce_pkg::PFX_EMPTY;
                pfx_len = 2'd0;
            end
        endcase

        n_b_head = '0;
        n_b_hlen = '0;
        if (r_a_flags.head_en) begin
            if (r_a_flags.pix != fce_pkg::CLASS_EMPTY && !r_a_flags.skip) begin
                n_b_head = (HW'(pfx) << gap_bits) | HW'(r_a_gap & gap_mask);
                n_b_hlen = LW'(pfx_len) + LW'(gap_bits);
            end else begin
                n_b_head = HW'(pfx);
                n_b_hlen = LW'(pfx_len);
            end
        end
    end

    // Trailing zeros shift the head left; anything past the word limit is dropped.
    always_comb begin
        room       = CW'(OW) - CW'(r_b_hlen);
        zeros_w    = 8'(r_b_zeros);
        room_w     = 8'(room);
        fill       = (zeros_w > room_w) ? room : CW'(r_b_zeros);
        n_out_bits = OW'(r_b_head) << fill;
        n_out_len  = CW'(r_b_hlen) + fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= i_valid;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
            if (en_c) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_flags <= i_flags;
            r_a_span  <= i_span;
            r_a_gap   <= i_gap;
            r_a_zeros <= i_zeros;
        end
        if (en_b) begin
            r_b_head  <= n_b_head;
            r_b_hlen  <= n_b_hlen;
            r_b_zeros <= r_a_zeros;
        end
        if (en_c) begin
            r_out_bits <= n_out_bits;
            r_out_len  <= n_out_len;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_code_bits   = r_out_bits;
    assign o_code_length = r_out_len;

`ifndef ASSERT_OFF
    a_no_bits_above_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_code_bits >> o_code_length) == '0))
        else $error("code bits set above the code length");

    a_length_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_code_length <= CW'(OW)))
        else $error("code length exceeds the output word");

    a_empty_head_is_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_hlen == '0) |-> (r_b_head == '0))
        else $error("head word holds bits but has zero length");
`endif

endmodule

FILE: design/fragment_coordinate_encoder_unit.sv
// Top level of the fragment coordinate encoder: configuration registers,
// position tracker and code builder. Depends on fce_pkg, fce_tracker and fce_packer.

// The unit takes one pixel class per clock in raster order and returns exactly one
// code word per pixel, right aligned in o_code_bits with its length in o_code_length
// (length zero when the pixel emits nothing). An accepted pixel's result passes through
// the descriptor register, the code-build register and the output register, and a new
// pixel is taken every cycle as long as the output side keeps up; the row and fragment
// counters in fce_tracker update in the accepting cycle, and that update being done in
// the accepting cycle is what sets the one-pixel-per-clock rate.
// Register writes (image width, unit length, fragment count) restart the row and
// should only be issued while no result is pending.

module fragment_coordinate_encoder_unit #(
    parameter int MAX_WIDTH     = fce_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FRAGMENTS = fce_pkg::DEF_MAX_FRAGMENTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fce_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [fce_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_pixel_class,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [fce_pkg::OUT_BITS-1:0]       o_code_bits,
    output logic [fce_pkg::CODE_LEN_W-1:0]     o_code_length
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH);
    localparam int FW = $clog2(MAX_FRAGMENTS + 1);

    // Zero acts as one; anything above the limit acts as the limit.
    function automatic logic [31:0] clamp_reg(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] r;
        if (v == 32'd0) begin
            r = 32'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    localparam logic [31:0] W_RST = clamp_reg(32'(fce_pkg::RST_IMAGE_WIDTH), 32'(MAX_WIDTH));
    localparam logic [31:0] U_RST = clamp_reg(32'(fce_pkg::RST_UNIT_LENGTH), 32'(MAX_WIDTH));
    localparam logic [31:0] N_RST = clamp_reg(32'(fce_pkg::RST_FRAGMENT_COUNT),
                                              32'(MAX_FRAGMENTS));

    logic [PW-1:0] r_w_last;
    logic [PW-1:0] r_u_last;
    logic [WW-1:0] r_u;
    logic [FW-1:0] r_n;

    logic [31:0] len_clamped;
    logic [31:0] cnt_clamped;
    logic        cfg_hit;
    logic        accept;

    fce_pkg::t_fce_flags flags;
    logic [WW-1:0]       span;
    logic [PW-1:0]       gap;
    logic [FW-1:0]       zeros;

    assign len_clamped = clamp_reg(32'(i_cfg_wdata), 32'(MAX_WIDTH));
    assign cnt_clamped = clamp_reg(32'(i_cfg_wdata[5:0]), 32'(MAX_FRAGMENTS));
    assign cfg_hit     = i_cfg_we && (i_cfg_addr == fce_pkg::CFG_IMAGE_WIDTH ||
                                      i_cfg_addr == fce_pkg::CFG_UNIT_LENGTH ||
                                      i_cfg_addr == fce_pkg::CFG_FRAGMENT_COUNT);
    assign accept      = i_valid && o_ready;

    // Registers hold clamped values, with width and length kept as last index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= PW'(W_RST - 32'd1);
            r_u_last <= PW'(U_RST - 32'd1);
            r_u      <= WW'(U_RST);
            r_n      <= FW'(N_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                fce_pkg::CFG_IMAGE_WIDTH: begin
                    r_w_last <= PW'(len_clamped - 32'd1);
                end
                fce_pkg::CFG_UNIT_LENGTH: begin
                    r_u_last <= PW'(len_clamped - 32'd1);
                    r_u      <= WW'(len_clamped);
                end
                fce_pkg::CFG_FRAGMENT_COUNT: begin
                    r_n <= FW'(cnt_clamped);
                end
                default: begin
                end
            endcase
        end
    end

    fce_tracker #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (cfg_hit),
        .i_accept      (accept),
        .i_pixel_class (i_pixel_class),
        .i_w_last      (r_w_last),
        .i_u_last      (r_u_last),
        .i_u           (r_u),
        .i_n           (r_n),
        .o_flags       (flags),
        .o_span        (span),
        .o_gap         (gap),
        .o_zeros       (zeros)
    );

    fce_packer #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_packer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_flags       (flags),
        .i_span        (span),
        .i_gap         (gap),
        .i_zeros       (zeros),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_bits   (o_code_bits),
        .o_code_length (o_code_length)
    );

endmodule
